// ----- rtl/tmab_pkg.sv -----
package tmab_pkg;

	// Default digit geometry of the conversion.
	localparam int DIGIT_BITS  = 8;
	localparam int DIGIT_COUNT = 2;

	// Fixed widths of the data and configuration ports.
	localparam int VALUE_W    = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_CARRY_MASK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_MASK   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_MASK  = 2'd2;

	// Control for one digit cell of the chain.
	typedef struct packed {
		logic load;       // capture a new transaction's digits
		logic shift_src;  // move source digits one cell toward the head
		logic shift_res;  // move result digits one cell toward the head
	} cell_ctrl_t;

endpackage

// ----- rtl/table_masked_arith_to_bool_top.sv -----
// Channel   Signals                                           Transaction
// --------  ------------------------------------------------  ------------------------
// input     start, busy, masked_value, value_mask             start high, busy low
// config    cfg_valid, cfg_ready, cfg_index, cfg_data         cfg_valid and cfg_ready
// result    done, boolean_share                               done high for one cycle
//
// After reset and after each write to a defined register the masked-carry table is
// rebuilt, one entry per cycle, covering DIGIT_COUNT << (DIGIT_BITS + 1) entries, 1024 by default.
// busy stays high during the rebuild. An item then reads the table once per digit, since
// each digit's table read needs the masked carry read for the digit below it from the
// single table memory. done rises after the last result digit is collected, and a new item
// may start in that same cycle. The receiver cannot stall the result.
module table_masked_arith_to_bool_top #(
	parameter int DIGIT_BITS  = tmab_pkg::DIGIT_BITS,
	parameter int DIGIT_COUNT = tmab_pkg::DIGIT_COUNT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [tmab_pkg::VALUE_W-1:0]    masked_value,
	input  logic [tmab_pkg::VALUE_W-1:0]    value_mask,
	output logic                            done,
	output logic [tmab_pkg::VALUE_W-1:0]    boolean_share,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tmab_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tmab_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int TABLE_DEPTH = DIGIT_COUNT << (DIGIT_BITS + 1);
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int WORD_W      = DIGIT_BITS * DIGIT_COUNT;
	localparam int CNT_W       = $clog2(DIGIT_COUNT + 1);
	localparam int VALUE_W     = tmab_pkg::VALUE_W;

	// Configuration registers.
	logic                            carry_mask_q;
	logic [tmab_pkg::CFG_DATA_W-1:0] low_mask_q;
	logic [tmab_pkg::CFG_DATA_W-1:0] high_mask_q;
	logic                            restart;

	// Sequencer state.
	logic                  run_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [1:0]            carry_q;
	logic [DIGIT_BITS-1:0] pend_q;
	logic                  done_q;

	logic                                   accept;
	logic                                   issue;
	logic                                   collect;
	logic                                   build_active;
	logic [DIGIT_COUNT-1:0][DIGIT_BITS-1:0] dmask;
	logic [WORD_W-1:0]                      a_word, r_word, m_word, b_word;

	logic                  tbl_we;
	logic [ADDR_W-1:0]     tbl_waddr;
	logic [DIGIT_BITS:0]   tbl_wdata;
	logic [ADDR_W-1:0]     tbl_raddr;
	logic [DIGIT_BITS:0]   tbl_rdata;

	logic [DIGIT_BITS-1:0] a_c [DIGIT_COUNT+1];
	logic [DIGIT_BITS-1:0] r_c [DIGIT_COUNT+1];
	logic [DIGIT_BITS-1:0] m_c [DIGIT_COUNT+1];
	logic [DIGIT_BITS-1:0] b_c [DIGIT_COUNT+1];

	logic [DIGIT_BITS+1:0]     t_sum;
	logic [DIGIT_BITS-1:0]     m_inv;
	logic                      beta_sel;
	logic [CNT_W+DIGIT_BITS:0] rd_wide;
	logic [DIGIT_BITS-1:0]     new_digit;

	tmab_pkg::cell_ctrl_t cell_ctrl;

	assign cfg_ready = 1'b1;
	assign busy      = build_active | run_q;
	assign accept    = start & ~busy;
	assign issue     = run_q & (cnt_q != CNT_W'(DIGIT_COUNT));
	assign collect   = run_q & (cnt_q != '0);

	// Register writes; a write to a defined register triggers a table rebuild.
	always_comb begin
		restart = 1'b0;
		if (cfg_valid) begin
			case (cfg_index)
				tmab_pkg::REG_CARRY_MASK: restart = 1'b1;
				tmab_pkg::REG_LOW_MASK:   restart = 1'b1;
				tmab_pkg::REG_HIGH_MASK:  restart = 1'b1;
				default:                  restart = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_mask_q <= 1'b0;
			low_mask_q   <= '0;
			high_mask_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				tmab_pkg::REG_CARRY_MASK: carry_mask_q <= cfg_data[0];
				tmab_pkg::REG_LOW_MASK:   low_mask_q   <= cfg_data;
				tmab_pkg::REG_HIGH_MASK:  high_mask_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Digit masks: the two byte masks, zero for any further digit.
	always_comb begin
		dmask = '0;
		for (int k = 0; k < DIGIT_COUNT; k++) begin
			if (k == 0) begin
				dmask[k] = low_mask_q[DIGIT_BITS-1:0];
			end else if (k == 1) begin
				dmask[k] = high_mask_q[DIGIT_BITS-1:0];
			end
		end
	end

	// Fit the input fields to the word; bits beyond the field read as zero.
	always_comb begin
		a_word = '0;
		r_word = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (i < VALUE_W) begin
				a_word[i] = masked_value[i];
				r_word[i] = value_mask[i];
			end
		end
		m_word = dmask;
	end

	tmab_build #(
		.DIGIT_BITS  (DIGIT_BITS),
		.DIGIT_COUNT (DIGIT_COUNT)
	) u_build (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (restart),
		.carry_mask (carry_mask_q),
		.dmask      (dmask),
		.active     (build_active),
		.we         (tbl_we),
		.waddr      (tbl_waddr),
		.wdata      (tbl_wdata)
	);

	tmab_ram #(
		.WIDTH (DIGIT_BITS + 1),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	assign cell_ctrl.load      = accept;
	assign cell_ctrl.shift_src = issue;
	assign cell_ctrl.shift_res = collect;

	// The tail of the chain is fed with zeros for sources and the new result digit.
	assign a_c[DIGIT_COUNT] = '0;
	assign r_c[DIGIT_COUNT] = '0;
	assign m_c[DIGIT_COUNT] = '0;
	assign b_c[DIGIT_COUNT] = new_digit;

	for (genvar k = 0; k < DIGIT_COUNT; k++) begin : g_cell
		tmab_cell #(
			.DIGIT_BITS (DIGIT_BITS)
		) u_cell (
			.clk  (clk),
			.ctrl (cell_ctrl),
			.ld_a (a_word[k*DIGIT_BITS +: DIGIT_BITS]),
			.ld_r (r_word[k*DIGIT_BITS +: DIGIT_BITS]),
			.ld_m (m_word[k*DIGIT_BITS +: DIGIT_BITS]),
			.nx_a (a_c[k+1]),
			.nx_r (r_c[k+1]),
			.nx_m (m_c[k+1]),
			.nx_b (b_c[k+1]),
			.a    (a_c[k]),
			.r    (r_c[k]),
			.m    (m_c[k]),
			.b    (b_c[k])
		);
		assign b_word[k*DIGIT_BITS +: DIGIT_BITS] = b_c[k];
	end

	// Head cell: digit of A minus mask word plus R, carried digit by digit.
	assign m_inv = ~m_c[0];
	assign t_sum = (DIGIT_BITS + 2)'(a_c[0]) + (DIGIT_BITS + 2)'(m_inv)
		+ (DIGIT_BITS + 2)'(r_c[0]) + (DIGIT_BITS + 2)'(carry_q);

	// The first digit starts from the carry mask, the others from the masked carry read.
	assign beta_sel  = (cnt_q == '0) ? carry_mask_q : tbl_rdata[DIGIT_BITS];
	assign rd_wide   = {cnt_q, beta_sel, t_sum[DIGIT_BITS-1:0]};
	assign tbl_raddr = rd_wide[ADDR_W-1:0];
	assign new_digit = tbl_rdata[DIGIT_BITS-1:0] ^ pend_q;

	// Sequencer: one table read per digit, then a final step to collect the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			cnt_q   <= '0;
			carry_q <= 2'd0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (accept) begin
				run_q   <= 1'b1;
				cnt_q   <= '0;
				carry_q <= 2'd1;
			end else if (run_q) begin
				if (cnt_q == CNT_W'(DIGIT_COUNT)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q   <= cnt_q + 1'b1;
					carry_q <= t_sum[DIGIT_BITS+1:DIGIT_BITS];
				end
			end
		end
	end

	// Unmasking term for the digit being read: its R digit and its mask digit.
	always_ff @(posedge clk) begin
		if (issue) begin
			pend_q <= r_c[0] ^ m_c[0];
		end
	end

	// The result word holds still in the chain while done is high.
	always_comb begin
		boolean_share = '0;
		for (int i = 0; i < VALUE_W; i++) begin
			if (i < WORD_W) begin
				boolean_share[i] = b_word[i];
			end
		end
	end

	assign done = done_q;

endmodule

// ----- rtl/tmab_ram.sv -----
module tmab_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/tmab_cell.sv -----
module tmab_cell #(
	parameter int DIGIT_BITS = tmab_pkg::DIGIT_BITS
) (
	input  logic                   clk,
	input  tmab_pkg::cell_ctrl_t   ctrl,
	input  logic [DIGIT_BITS-1:0]  ld_a,
	input  logic [DIGIT_BITS-1:0]  ld_r,
	input  logic [DIGIT_BITS-1:0]  ld_m,
	input  logic [DIGIT_BITS-1:0]  nx_a,
	input  logic [DIGIT_BITS-1:0]  nx_r,
	input  logic [DIGIT_BITS-1:0]  nx_m,
	input  logic [DIGIT_BITS-1:0]  nx_b,
	output logic [DIGIT_BITS-1:0]  a,
	output logic [DIGIT_BITS-1:0]  r,
	output logic [DIGIT_BITS-1:0]  m,
	output logic [DIGIT_BITS-1:0]  b
);

	logic [DIGIT_BITS-1:0] a_q, r_q, m_q, b_q;

	// Source digits are loaded in parallel and then walk toward the head cell.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			a_q <= ld_a;
			r_q <= ld_r;
			m_q <= ld_m;
		end else if (ctrl.shift_src) begin
			a_q <= nx_a;
			r_q <= nx_r;
			m_q <= nx_m;
		end
	end

	// Finished result digits enter at the tail and walk toward the head.
	always_ff @(posedge clk) begin
		if (ctrl.shift_res) begin
			b_q <= nx_b;
		end
	end

	assign a = a_q;
	assign r = r_q;
	assign m = m_q;
	assign b = b_q;

endmodule

// ----- rtl/tmab_build.sv -----
module tmab_build #(
	parameter int DIGIT_BITS  = tmab_pkg::DIGIT_BITS,
	parameter int DIGIT_COUNT = tmab_pkg::DIGIT_COUNT,
	localparam int TABLE_DEPTH = DIGIT_COUNT << (DIGIT_BITS + 1),
	localparam int ADDR_W      = $clog2(TABLE_DEPTH)
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   restart,
	input  logic                                   carry_mask,
	input  logic [DIGIT_COUNT-1:0][DIGIT_BITS-1:0] dmask,
	output logic                                   active,
	output logic                                   we,
	output logic [ADDR_W-1:0]                      waddr,
	output logic [DIGIT_BITS:0]                    wdata
);

	logic [ADDR_W-1:0]     idx_q;
	logic                  active_q;
	logic [ADDR_W-1:0]     digit;
	logic [DIGIT_BITS-1:0] r_d;
	logic [DIGIT_BITS:0]   sum;
	logic                  last;

	assign last = (idx_q == ADDR_W'(TABLE_DEPTH - 1));

	// Sweep every table slot once, one entry per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			active_q <= 1'b1;
		end else if (restart) begin
			idx_q    <= '0;
			active_q <= 1'b1;
		end else if (active_q) begin
			if (last) begin
				idx_q    <= '0;
				active_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// Pick the mask of the digit position that the slot belongs to.
	always_comb begin
		digit = idx_q >> (DIGIT_BITS + 1);
		r_d   = '0;
		for (int k = 0; k < DIGIT_COUNT; k++) begin
			if (digit == ADDR_W'(k)) begin
				r_d = dmask[k];
			end
		end
	end

	// An entry holds the digit plus its mask plus the unmasked carry-in, hidden
	// under the carry mask bit and the digit mask.
	assign sum = (DIGIT_BITS + 1)'(idx_q[DIGIT_BITS-1:0]) + (DIGIT_BITS + 1)'(r_d)
		+ (DIGIT_BITS + 1)'(idx_q[DIGIT_BITS] ^ carry_mask);

	assign active = active_q;
	assign we     = active_q;
	assign waddr  = idx_q;
	assign wdata  = sum ^ {carry_mask, r_d};

endmodule
